// ===== src/sdspi_pkg.sv =====
package sdspi_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_POWERUP, PH_PRE1, PH_PRE2, PH_CMD_BYTES, PH_POLL, PH_OCR8,
    PH_ACMD_TICK, PH_OCR58, PH_FINAL, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
    PH_WR_GAP, PH_WR_TOKEN, PH_WR_NEED, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP,
    PH_WR_BUSY
  } phase_e;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2, OP_RX = 3'd3,
    OP_WBYTE = 3'd4, OP_TICK = 3'd5
  } op_e;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_RESET_FAIL = 3'd1;
  localparam logic [2:0] ST_INIT_FAIL = 3'd2;
  localparam logic [2:0] ST_CMD_ERR = 3'd3;
  localparam logic [2:0] ST_TOKEN_TO = 3'd4;
  localparam logic [2:0] ST_WR_REJ = 3'd5;

  localparam logic [2:0] CFG_POWER_UP = 3'd0;
  localparam logic [2:0] CFG_RESET_RETRY = 3'd1;
  localparam logic [2:0] CFG_OPCOND_RETRY = 3'd2;
  localparam logic [2:0] CFG_POLL_LIMIT = 3'd3;
  localparam logic [2:0] CFG_RD_TIMEOUT = 3'd4;
  localparam logic [2:0] CFG_BUSY_TIMEOUT = 3'd5;

  localparam int unsigned BlockBytes = 512;
  localparam logic [9:0] BLOCK_LAST = 10'(BlockBytes - 1);
  localparam logic [31:0] HC_ARG = 32'h4000_0000;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_high;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       need_write_byte;
    logic       done_res;
    logic [2:0] status;
    logic [1:0] card_type;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [7:0]  power_up_bytes;
    logic [15:0] reset_cmd_retries;
    logic [15:0] op_cond_retries;
    logic [7:0]  response_poll_limit;
    logic [15:0] read_token_timeout_ms;
    logic [15:0] busy_timeout_ms;
  } cfg_t;

endpackage

// ===== src/sdspi_cmd_byte.sv =====
module sdspi_cmd_byte import sdspi_pkg::*; (
  input  logic [2:0]  k_i,
  input  logic        app_i,
  input  logic [5:0]  idx_i,
  input  logic [31:0] arg_i,
  output logic [7:0]  byte_o
);
  logic [5:0]  idx;
  logic [31:0] arg;
  always_comb begin
    idx = app_i ? 6'd55 : idx_i;
    arg = app_i ? 32'd0 : arg_i;
    case (k_i)
      3'd0: byte_o = {2'b01, idx};
      3'd1: byte_o = arg[31:24];
      3'd2: byte_o = arg[23:16];
      3'd3: byte_o = arg[15:8];
      3'd4: byte_o = arg[7:0];
      default: byte_o = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'hFF);
    endcase
  end
endmodule

// ===== src/sd_card_spi_mode_controller_core.sv =====
// SD card SPI-mode master. One event per input transaction (op 0 init, 1 read, 2 write,
// 3 SPI byte exchanged, 4 write payload byte, 5 millisecond tick), one result per event.
// An event is decoded combinationally from the state registers into a result register,
// so a transaction is taken every clock cycle unless both slots are full; the result is
// registered in the output slot, or in the skid slot while the output waits.
module sd_card_spi_mode_controller_core import sdspi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // op[2:0], sector[34:3], rx_byte[42:35], write_byte[50:43]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tx_valid, tx_byte, cs_high, read_valid, read_byte,
                                      // need_write_byte, done_res, status, card_type, busy_res
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  cfg_t cfg_q;
  phase_e phase_q, phase_d;
  logic [5:0]  cidx_q, cidx_d;
  logic        app_q, app_d, cs_q, cs_d, acc;
  logic [31:0] arg_q, arg_d, ocr_q, ocr_d, ocr_n;
  logic [9:0]  bc_q, bc_d, bc_inc;
  logic [7:0]  poll_q, poll_d;
  logic [15:0] retry_q, retry_d, tick_q, tick_d;
  logic [1:0]  type_q, type_d, kind_q, kind_d;
  logic [7:0]  lastr_q, lastr_d;
  logic [2:0]  op;
  logic [31:0] sector;
  logic [7:0]  rx, wb, cb;
  logic [2:0]  cb_k;
  result_t res;
  logic        ov_q, sv_q;
  result_t     out_q, skid_q;

  assign op = s_axis_tdata[2:0];
  assign sector = s_axis_tdata[34:3];
  assign rx = s_axis_tdata[42:35];
  assign wb = s_axis_tdata[50:43];
  assign s_axis_tready = !sv_q;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign bc_inc = bc_q + 10'd1;
  assign ocr_n = {ocr_q[23:0], rx};
  assign cb_k = (phase_q == PH_PRE2) ? 3'd0 : bc_inc[2:0];

  sdspi_cmd_byte u_cmd (.k_i(cb_k), .app_i(app_q), .idx_i(cidx_q), .arg_i(arg_q),
                        .byte_o(cb));

  always_comb begin
    phase_d = phase_q; cidx_d = cidx_q; app_d = app_q; cs_d = cs_q; arg_d = arg_q;
    ocr_d = ocr_q; bc_d = bc_q; poll_d = poll_q; retry_d = retry_q; tick_d = tick_q;
    type_d = type_q; kind_d = kind_q; lastr_d = lastr_q;
    res = '0;
    case (op)
      OP_INIT: if (phase_q == PH_IDLE) begin
        kind_d = 2'd0; type_d = 2'd0; cs_d = 1'b1; retry_d = cfg_q.reset_cmd_retries;
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
        if (cfg_q.power_up_bytes != 8'd0) begin
          bc_d = {2'b0, cfg_q.power_up_bytes}; phase_d = PH_POWERUP;
        end else begin
          cidx_d = 6'd0; arg_d = '0; app_d = 1'b0; phase_d = PH_PRE1;
        end
      end
      OP_READ, OP_WRITE: if (phase_q == PH_IDLE) begin
        kind_d = op[1:0]; cidx_d = (op == OP_READ) ? 6'd17 : 6'd24;
        arg_d = (type_q != 2'd3) ? {sector[22:0], 9'd0} : sector;
        app_d = 1'b0; phase_d = PH_PRE1; cs_d = 1'b1;
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
      end
      OP_WBYTE: if (phase_q == PH_WR_NEED) begin
        phase_d = PH_WR_DATA; res.tx_valid = 1'b1; res.tx_byte = wb;
      end
      OP_TICK: begin
        if (phase_q == PH_ACMD_TICK) begin
          res.tx_valid = 1'b1; res.tx_byte = 8'hFF; cs_d = 1'b1;
          if (lastr_q == 8'd0) begin
            if (arg_q == HC_ARG) begin
              cidx_d = 6'd58; arg_d = '0; app_d = 1'b0; phase_d = PH_PRE1;
            end else begin
              type_d = 2'd1; phase_d = PH_FINAL;
            end
          end else begin
            retry_d = retry_q - 16'd1;
            if (retry_d == 16'd0) phase_d = PH_FINAL;
            else begin
              cidx_d = 6'd41; app_d = 1'b1; phase_d = PH_PRE1;
            end
          end
        end else if (phase_q == PH_RD_TOKEN || phase_q == PH_WR_BUSY) begin
          if (tick_q != 16'hFFFF) tick_d = tick_q + 16'd1;
        end
      end
      OP_RX: begin
        res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
        case (phase_q)
          PH_POWERUP: begin
            bc_d = bc_q - 10'd1;
            if (bc_d == 10'd0) begin
              cidx_d = 6'd0; arg_d = '0; app_d = 1'b0; phase_d = PH_PRE1; cs_d = 1'b1;
            end
          end
          PH_PRE1: begin cs_d = 1'b0; phase_d = PH_PRE2; end
          PH_PRE2: begin bc_d = '0; phase_d = PH_CMD_BYTES; res.tx_byte = cb; end
          PH_CMD_BYTES: begin
            bc_d = bc_inc;
            if (bc_inc < 10'd6) res.tx_byte = cb;
            else begin phase_d = PH_POLL; poll_d = cfg_q.response_poll_limit; end
          end
          PH_POLL: begin
            poll_d = poll_q - 8'd1;
            if (!(rx[7] && poll_d != 8'd0)) begin
              if (!rx[7]) poll_d = poll_q;
              lastr_d = rx;
              if (app_q && rx <= 8'd1) begin
                app_d = 1'b0; phase_d = PH_PRE1; cs_d = 1'b1;
              end else begin
                app_d = 1'b0;
                case (cidx_q)
                  6'd0: if (rx == 8'h01) begin
                    cidx_d = 6'd8; arg_d = 32'h1AA; phase_d = PH_PRE1; cs_d = 1'b1;
                  end else begin
                    retry_d = retry_q - 16'd1;
                    if (retry_d == 16'd0) begin
                      res = '0; res.done_res = 1'b1; res.status = ST_RESET_FAIL;
                      phase_d = PH_IDLE; cs_d = 1'b1;
                    end else begin
                      arg_d = '0; phase_d = PH_PRE1; cs_d = 1'b1;
                    end
                  end
                  6'd8: if (rx == 8'h01) begin
                    phase_d = PH_OCR8; bc_d = '0;
                  end else begin
                    retry_d = cfg_q.op_cond_retries; cidx_d = 6'd41; arg_d = '0;
                    app_d = 1'b1; phase_d = PH_PRE1; cs_d = 1'b1;
                  end
                  6'd41: begin res = '0; phase_d = PH_ACMD_TICK; end
                  6'd58: begin phase_d = PH_OCR58; bc_d = '0; end
                  6'd17, 6'd24: if (rx != 8'd0) begin
                    res = '0; res.done_res = 1'b1; res.status = ST_CMD_ERR;
                    phase_d = PH_IDLE; cs_d = 1'b1;
                  end else if (cidx_q == 6'd17) begin
                    phase_d = PH_RD_TOKEN; tick_d = '0;
                  end else phase_d = PH_WR_GAP;
                  default: begin
                    res = '0; res.done_res = 1'b1; res.status = ST_CMD_ERR;
                    phase_d = PH_IDLE; cs_d = 1'b1;
                  end
                endcase
              end
            end
          end
          PH_OCR8, PH_OCR58: begin
            ocr_d = ocr_n; bc_d = bc_inc;
            if (bc_inc >= 10'd4) begin
              cs_d = 1'b1; phase_d = PH_FINAL;
              if (phase_q == PH_OCR58) type_d = ocr_n[30] ? 2'd3 : 2'd2;
              else if (ocr_n[15:0] == 16'h01AA) begin
                retry_d = cfg_q.op_cond_retries; cidx_d = 6'd41; arg_d = HC_ARG;
                app_d = 1'b1; phase_d = PH_PRE1;
              end
            end
          end
          PH_FINAL: begin
            res = '0; res.done_res = 1'b1; phase_d = PH_IDLE; cs_d = 1'b1;
            res.status = (kind_q == 2'd0 && type_q == 2'd0) ? ST_INIT_FAIL : ST_OK;
          end
          PH_RD_TOKEN: begin
            if (tick_q > cfg_q.read_token_timeout_ms) begin
              res = '0; res.done_res = 1'b1; res.status = ST_TOKEN_TO;
              phase_d = PH_IDLE; cs_d = 1'b1;
            end else if (rx == 8'hFE) begin
              phase_d = PH_RD_DATA; bc_d = '0;
            end
          end
          PH_RD_DATA: begin
            res.read_valid = 1'b1; res.read_byte = rx; bc_d = bc_inc;
            if (bc_q == BLOCK_LAST) begin phase_d = PH_RD_CRC; bc_d = '0; end
          end
          PH_RD_CRC: begin
            bc_d = bc_inc;
            if (bc_inc >= 10'd2) begin phase_d = PH_FINAL; cs_d = 1'b1; end
          end
          PH_WR_GAP: begin phase_d = PH_WR_TOKEN; res.tx_byte = 8'hFE; end
          PH_WR_TOKEN: begin res = '0; bc_d = '0; phase_d = PH_WR_NEED; end
          PH_WR_DATA: begin
            bc_d = bc_inc;
            if (bc_q == BLOCK_LAST) begin phase_d = PH_WR_CRC; bc_d = '0; end
            else begin res = '0; phase_d = PH_WR_NEED; end
          end
          PH_WR_CRC: begin
            bc_d = bc_inc;
            if (bc_inc >= 10'd2) phase_d = PH_WR_RESP;
          end
          PH_WR_RESP: begin
            if (rx[4:0] != 5'h05) begin
              res = '0; res.done_res = 1'b1; res.status = ST_WR_REJ;
              phase_d = PH_IDLE; cs_d = 1'b1;
            end else begin
              tick_d = '0;
              if (cfg_q.busy_timeout_ms == 16'd0) begin
                phase_d = PH_FINAL; cs_d = 1'b1;
              end else phase_d = PH_WR_BUSY;
            end
          end
          PH_WR_BUSY: begin
            if (rx == 8'hFF || tick_q >= cfg_q.busy_timeout_ms) begin
              phase_d = PH_FINAL; cs_d = 1'b1;
            end
          end
          default: res = '0;
        endcase
      end
      default: ;
    endcase
    res.cs_high = cs_d;
    res.need_write_byte = (phase_d == PH_WR_NEED);
    res.card_type = type_d;
    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{8'd10, 16'd100, 16'd1000, 8'd10, 16'd500, 16'd500};
      phase_q <= PH_IDLE; cidx_q <= '0; app_q <= 1'b0; cs_q <= 1'b1; arg_q <= '0;
      ocr_q <= '0; bc_q <= '0; poll_q <= '0; retry_q <= '0; tick_q <= '0;
      type_q <= '0; kind_q <= '0; lastr_q <= 8'hFF;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POWER_UP:     cfg_q.power_up_bytes <= cfg_data_i[7:0];
          CFG_RESET_RETRY:  cfg_q.reset_cmd_retries <= cfg_data_i;
          CFG_OPCOND_RETRY: cfg_q.op_cond_retries <= cfg_data_i;
          CFG_POLL_LIMIT:   cfg_q.response_poll_limit <= cfg_data_i[7:0];
          CFG_RD_TIMEOUT:   cfg_q.read_token_timeout_ms <= cfg_data_i;
          CFG_BUSY_TIMEOUT: cfg_q.busy_timeout_ms <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc) begin
        phase_q <= phase_d; cidx_q <= cidx_d; app_q <= app_d; cs_q <= cs_d; arg_q <= arg_d;
        ocr_q <= ocr_d; bc_q <= bc_d; poll_q <= poll_d; retry_q <= retry_d;
        tick_q <= tick_d; type_q <= type_d; kind_q <= kind_d; lastr_q <= lastr_d;
      end
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      if (!ov_q || m_axis_tready) begin
        ov_q <= sv_q || acc;
        sv_q <= 1'b0;
      end else if (acc) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || m_axis_tready) out_q <= sv_q ? skid_q : res;
    else if (acc) skid_q <= res;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {5'b0, out_q.busy_res, out_q.card_type, out_q.status,
                         out_q.done_res, out_q.need_write_byte, out_q.read_byte,
                         out_q.read_valid, out_q.cs_high, out_q.tx_byte, out_q.tx_valid};

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q) else $error("skid full with output empty");
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> cs_q) else $error("chip select low while idle");
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> ov_q) else $error("accepted transaction lost");
endmodule
